>>> rtl/cnv_pkg.sv
// Shared types and constants of the streaming 2D convolution block.
`timescale 1ns / 1ps
`default_nettype none

package cnv_pkg;

	localparam int PIX_W      = 16;
	localparam int COEF_W     = 12;
	localparam int LANES      = 5;
	localparam int COEF_ROW_W = COEF_W * LANES;
	localparam int BIAS_W     = 16;
	localparam int SIZE_W     = 7;
	localparam int POS_W      = 6;
	localparam int POS_CAP    = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_ROW_W;

	// Product of an unsigned pixel and a signed coefficient, and the sums.
	localparam int PROD_W = PIX_W + 1 + COEF_W;
	localparam int ROW_W  = PROD_W + 3;
	localparam int SUM_W  = PROD_W + 5;

	localparam logic [COEF_ROW_W-1:0] COEF_RESET_EVEN = 60'd72057598332895488;
	localparam logic [COEF_ROW_W-1:0] COEF_RESET_ODD  = 60'd17592187092992;
	localparam logic [BIAS_W-1:0]     BIAS_RESET      = 16'd256;
	localparam logic [SIZE_W-1:0]     SIZE_RESET      = 7'd28;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_ROW_0 = 3'd0,
		CFG_COEF_ROW_1 = 3'd1,
		CFG_COEF_ROW_2 = 3'd2,
		CFG_COEF_ROW_3 = 3'd3,
		CFG_COEF_ROW_4 = 3'd4,
		CFG_BIAS_VALUE = 3'd5,
		CFG_IMAGE_SIZE = 3'd6
	} cfg_idx_t;

	// Position and flags that travel with each pixel down the pipeline.
	typedef struct packed {
		logic             res;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             eoi;
	} meta_t;

endpackage

`default_nettype wire

>>> rtl/cnv_ifs.sv
// Handshake interfaces for the pixel, feature and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface cnv_pix_if;
	logic                      valid;
	logic                      ready;
	logic [cnv_pkg::PIX_W-1:0] pixel;
	logic                      start_of_image;

	modport source (output valid, output pixel, output start_of_image, input ready);
	modport sink (input valid, input pixel, input start_of_image, output ready);
endinterface

interface cnv_feat_if;
	logic                      valid;
	logic                      ready;
	logic [cnv_pkg::PIX_W-1:0] feature_value;
	logic [cnv_pkg::POS_W-1:0] out_row;
	logic [cnv_pkg::POS_W-1:0] out_col;
	logic                      end_of_image;

	modport source (output valid, output feature_value, output out_row, output out_col,
		output end_of_image, input ready);
	modport sink (input valid, input feature_value, input out_row, input out_col,
		input end_of_image, output ready);
endinterface

interface cnv_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cnv_pkg::CFG_IDX_W-1:0]  index;
	logic [cnv_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cnv_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module cnv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/cnv_window.sv
// Position counters, line store memory with forwarding, and the pixel window.
`timescale 1ns / 1ps
`default_nettype none

module cnv_window #(
	parameter int KERNEL    = 5,
	parameter int MAX_WIDTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                advance,
	input  wire logic                                accept,
	input  wire logic [cnv_pkg::PIX_W-1:0]           pixel,
	input  wire logic                                start_of_image,
	input  wire logic [cnv_pkg::SIZE_W-1:0]          image_size,
	output logic [KERNEL-1:0][KERNEL-1:0][cnv_pkg::PIX_W-1:0] window,
	output logic                                     valid_s2,
	output cnv_pkg::meta_t                           meta_s2
);

	localparam int DEPTH = (MAX_WIDTH < cnv_pkg::POS_CAP) ? MAX_WIDTH : cnv_pkg::POS_CAP;
	localparam int AW    = $clog2(DEPTH);
	localparam int LINES = (KERNEL > 1) ? KERNEL - 1 : 1;
	localparam int LW    = LINES * cnv_pkg::PIX_W;
	localparam int PW1   = cnv_pkg::POS_W + 1;

	logic [cnv_pkg::POS_W-1:0] col_q, row_q;
	logic [PW1-1:0]            n, c0, r0, c_nx, r_nx;
	logic [DEPTH-1:0]          ent_vld_q;

	logic                      valid_s1, fwd_s1, vld_s1;
	cnv_pkg::meta_t            meta_s1;
	logic [AW-1:0]             addr_s1;
	logic [cnv_pkg::PIX_W-1:0] pixel_s1;
	logic [LW-1:0]             fwd_data_s1;

	logic [LW-1:0]                         rd_data;
	logic [LINES-1:0][cnv_pkg::PIX_W-1:0]  line, wr_line;
	logic [KERNEL-1:0][cnv_pkg::PIX_W-1:0] column;
	logic                                  wr_en;
	logic [AW-1:0]                         rd_addr;
	cnv_pkg::meta_t                        meta_in;

	// Active size clamped to the kernel and to the line store depth.
	always_comb begin
		if (image_size < PW1'(KERNEL)) begin
			n = PW1'(KERNEL);
		end else if (image_size > PW1'(DEPTH)) begin
			n = PW1'(DEPTH);
		end else begin
			n = image_size;
		end
	end

	always_comb begin
		c0 = start_of_image ? '0 : {1'b0, col_q};
		r0 = start_of_image ? '0 : {1'b0, row_q};
		if (c0 >= n) begin
			c0 = '0;
			r0 = r0 + PW1'(1);
		end
		if (r0 >= n) begin
			r0 = '0;
		end
		if (c0 + PW1'(1) >= n) begin
			c_nx = '0;
			r_nx = (r0 + PW1'(1) >= n) ? '0 : r0 + PW1'(1);
		end else begin
			c_nx = c0 + PW1'(1);
			r_nx = r0;
		end
		meta_in.res = (r0 >= PW1'(KERNEL - 1)) && (c0 >= PW1'(KERNEL - 1));
		meta_in.row = cnv_pkg::POS_W'(r0 - PW1'(KERNEL - 1));
		meta_in.col = cnv_pkg::POS_W'(c0 - PW1'(KERNEL - 1));
		meta_in.eoi = (r0 == n - PW1'(1)) && (c0 == n - PW1'(1));
		rd_addr     = c0[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= c_nx[cnv_pkg::POS_W-1:0];
			row_q <= r_nx[cnv_pkg::POS_W-1:0];
		end
	end

	// Line store contents: forwarded write, stored word, or zero if never written.
	always_comb begin
		if (fwd_s1) begin
			line = fwd_data_s1;
		end else if (vld_s1) begin
			line = rd_data;
		end else begin
			line = '0;
		end
		for (int k = 0; k < KERNEL - 1; k++) begin
			column[k] = line[k];
		end
		column[KERNEL-1] = pixel_s1;
		wr_line = line;
		for (int k = 0; k < KERNEL - 1; k++) begin
			wr_line[k] = column[k+1];
		end
	end

	assign wr_en = valid_s1 && advance;

	cnv_ram #(
		.WIDTH(LW),
		.DEPTH(DEPTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(wr_line),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			window    <= '0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ent_vld_q[addr_s1] <= 1'b1;
				for (int k = 0; k < KERNEL; k++) begin
					for (int l = 0; l < KERNEL - 1; l++) begin
						window[k][l] <= window[k][l+1];
					end
					window[k][KERNEL-1] <= column[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1     <= meta_in;
			addr_s1     <= rd_addr;
			pixel_s1    <= pixel;
			fwd_s1      <= valid_s1 && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_line;
			vld_s1      <= ent_vld_q[rd_addr];
			meta_s2     <= meta_s1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/cnv_mac.sv
// Window products and a registered adder tree giving the full window sum.
`timescale 1ns / 1ps
`default_nettype none

module cnv_mac #(
	parameter int KERNEL = 5
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              advance,
	input  wire logic [KERNEL-1:0][KERNEL-1:0][cnv_pkg::PIX_W-1:0] window,
	input  wire logic [cnv_pkg::LANES-1:0][cnv_pkg::COEF_ROW_W-1:0] coef_rows,
	input  wire logic                                              valid_s2,
	input  wire cnv_pkg::meta_t                                    meta_s2,
	output logic                                                   valid_s5,
	output cnv_pkg::meta_t                                         meta_s5,
	output logic signed [cnv_pkg::SUM_W-1:0]                       sum_s5
);

	logic                               valid_s3, valid_s4;
	cnv_pkg::meta_t                     meta_s3, meta_s4;
	logic signed [cnv_pkg::PROD_W-1:0]  prod_s3 [KERNEL][KERNEL];
	logic signed [cnv_pkg::ROW_W-1:0]   row_s4 [KERNEL];
	logic signed [cnv_pkg::ROW_W-1:0]   row_sum [KERNEL];
	logic signed [cnv_pkg::SUM_W-1:0]   total;

	always_comb begin
		for (int k = 0; k < KERNEL; k++) begin
			row_sum[k] = '0;
			for (int l = 0; l < KERNEL; l++) begin
				row_sum[k] = row_sum[k] + cnv_pkg::ROW_W'(prod_s3[k][l]);
			end
		end
		total = '0;
		for (int k = 0; k < KERNEL; k++) begin
			total = total + cnv_pkg::SUM_W'(row_s4[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < KERNEL; k++) begin
				for (int l = 0; l < KERNEL; l++) begin
					prod_s3[k][l] <= $signed({1'b0, window[k][l]})
						* $signed(coef_rows[k][cnv_pkg::COEF_W*l +: cnv_pkg::COEF_W]);
				end
				row_s4[k] <= row_sum[k];
			end
			sum_s5  <= total;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

endmodule

`default_nettype wire

>>> rtl/conv2d_valid_relu_bias.sv
// Top level: streaming valid 2D convolution with ReLU, bias and saturation.
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Beat contents
//  --------+-----------+----------------------------------------------------
//  pix     | in        | pixel (Q8.8 unsigned), start_of_image
//  feat    | out       | feature_value (Q8.8), out_row, out_col, end_of_image
//  cfg     | in        | index (register number), data (write value)
//
// One pixel beat is taken per cycle unless the pipeline holds; the line store
// memory port pair (one read at accept, one write as the beat leaves the first
// stage) sets that figure. Reset clears the line store valid bits, the window and
// the counters, and loads the configuration registers with their reset values.
// The pipeline only holds when a result in its last stage meets a full, stalled
// output register; pixels that produce no result never cause a hold.

module conv2d_valid_relu_bias #(
	parameter int KERNEL    = 5,
	parameter int MAX_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cnv_pix_if.sink   pix,
	cnv_feat_if.source feat,
	cnv_cfg_if.sink   cfg
);

	localparam int SIZE_CAP = (MAX_WIDTH < cnv_pkg::POS_CAP) ? MAX_WIDTH : cnv_pkg::POS_CAP;
	localparam int RELU_W   = cnv_pkg::SUM_W - 8;

	// Configuration registers. Writes beyond the register list are dropped.
	logic [cnv_pkg::LANES-1:0][cnv_pkg::COEF_ROW_W-1:0] coef_q;
	logic signed [cnv_pkg::BIAS_W-1:0]                  bias_q;
	logic [cnv_pkg::SIZE_W-1:0]                         size_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= cnv_pkg::COEF_RESET_EVEN;
			coef_q[1] <= cnv_pkg::COEF_RESET_ODD;
			coef_q[2] <= cnv_pkg::COEF_RESET_EVEN;
			coef_q[3] <= cnv_pkg::COEF_RESET_ODD;
			coef_q[4] <= cnv_pkg::COEF_RESET_EVEN;
			bias_q    <= cnv_pkg::BIAS_RESET;
			size_q    <= cnv_pkg::SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cnv_pkg::cfg_idx_t'(cfg.index))
				cnv_pkg::CFG_COEF_ROW_0: coef_q[0] <= cfg.data;
				cnv_pkg::CFG_COEF_ROW_1: coef_q[1] <= cfg.data;
				cnv_pkg::CFG_COEF_ROW_2: coef_q[2] <= cfg.data;
				cnv_pkg::CFG_COEF_ROW_3: coef_q[3] <= cfg.data;
				cnv_pkg::CFG_COEF_ROW_4: coef_q[4] <= cfg.data;
				cnv_pkg::CFG_BIAS_VALUE: bias_q <= cfg.data[cnv_pkg::BIAS_W-1:0];
				cnv_pkg::CFG_IMAGE_SIZE: size_q <= cfg.data[cnv_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it only waits when a result at its end
	// has nowhere to go.
	logic                                                  advance, accept;
	logic                                                  valid_s2, valid_s5;
	cnv_pkg::meta_t                                        meta_s2, meta_s5;
	logic [KERNEL-1:0][KERNEL-1:0][cnv_pkg::PIX_W-1:0]     window;
	logic signed [cnv_pkg::SUM_W-1:0]                      sum_s5;

	logic                      out_valid_q;
	logic [cnv_pkg::PIX_W-1:0] out_value_q;
	cnv_pkg::meta_t            out_meta_q;

	assign advance   = !(valid_s5 && meta_s5.res && out_valid_q && !feat.ready);
	assign pix.ready = advance;
	assign accept    = pix.valid && advance;

	cnv_window #(
		.KERNEL   (KERNEL),
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.accept        (accept),
		.pixel         (pix.pixel),
		.start_of_image(pix.start_of_image),
		.image_size    (size_q),
		.window        (window),
		.valid_s2      (valid_s2),
		.meta_s2       (meta_s2)
	);

	cnv_mac #(
		.KERNEL(KERNEL)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.window   (window),
		.coef_rows(coef_q),
		.valid_s2 (valid_s2),
		.meta_s2  (meta_s2),
		.valid_s5 (valid_s5),
		.meta_s5  (meta_s5),
		.sum_s5   (sum_s5)
	);

	// ReLU first (a non-positive sum gives zero, otherwise truncate to Q18.8),
	// then the bias, then saturation to the unsigned 16-bit range.
	logic [RELU_W-1:0]       relu;
	logic signed [RELU_W:0]  biased;
	logic [cnv_pkg::PIX_W-1:0] feature;

	always_comb begin
		relu   = (sum_s5 > 0) ? sum_s5[cnv_pkg::SUM_W-1:8] : '0;
		biased = $signed({1'b0, relu}) + (RELU_W + 1)'(bias_q);
		if (biased < 0) begin
			feature = '0;
		end else if (biased > $signed((RELU_W + 1)'(16'hFFFF))) begin
			feature = '1;
		end else begin
			feature = biased[cnv_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && valid_s5 && meta_s5.res) begin
			out_valid_q <= 1'b1;
		end else if (feat.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s5 && meta_s5.res) begin
			out_value_q <= feature;
			out_meta_q  <= meta_s5;
		end
	end

	assign feat.valid         = out_valid_q;
	assign feat.feature_value = out_value_q;
	assign feat.out_row       = out_meta_q.row;
	assign feat.out_col       = out_meta_q.col;
	assign feat.end_of_image  = out_meta_q.eoi;

	// The input side only waits behind a result beat that is being held off.
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (feat.valid && !feat.ready))
		else $error("pixel channel stalled without a held result beat");

	// The last result of a square image sits on the diagonal.
	a_eoi_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(feat.valid && feat.end_of_image) |-> (feat.out_row == feat.out_col))
		else $error("end of image flagged off the diagonal");

	// Output positions never exceed the largest possible output map.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		feat.valid |-> ((feat.out_row <= cnv_pkg::POS_W'(SIZE_CAP - KERNEL))
			&& (feat.out_col <= cnv_pkg::POS_W'(SIZE_CAP - KERNEL))))
		else $error("output position beyond the output map");

	// A held result in the last stage is still there in the next cycle.
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && meta_s5.res && !advance) |=> (valid_s5 && meta_s5.res))
		else $error("result dropped while the output register was full");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the streaming 5x5 convolution with ReLU, bias and saturation.
`timescale 1ns / 1ps

module tb;
	import cnv_pkg::*;

	// Window edge and the deepest line the predictor keeps. These follow the block's
	// default parameters, which the instance below leaves untouched.
	localparam int KSZ      = 5;
	localparam int LINE_CAP = 64;

	// Register index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	// Settings of the random part. The first few pin the extremes of the coefficients,
	// the bias and the image size; the rest are drawn at random.
	localparam int PH_SAT_HIGH     = 0;  // largest coefficients and bias: clips at the top
	localparam int PH_NEG_LOW      = 1;  // most negative filter and bias: clips at zero
	localparam int PH_NEG_BIAS     = 2;  // ReLU removes the sum, the largest bias remains
	localparam int PH_ZERO         = 3;  // zero filter, size below the window edge
	localparam int PH_RESET_FILTER = 4;  // reset filter and bias rewritten, size just below 5
	localparam int PH_WIDE         = 5;  // size far above the limit, so the widest image
	localparam int PH_HOLD         = 6;  // size just above the limit; output held off
	localparam int PH_SHRINK       = 7;  // small size with the position left far outside
	localparam int N_SETTINGS      = 18;

	localparam int WIDE_BEATS   = 300;
	localparam int HOLD_BEATS   = 120;
	localparam int HOLD_CYCLES  = 300;
	// Drain wait after the last owed result, with margin for the pipeline.
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             eoi;
	} feature_t;

	// One run of the directed table: the same pixel repeated, start of image on the
	// first beat only, and, where pinned, the result written out by hand for the last.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             sof;
		logic [7:0]       beats;
		logic             pinned;
		feature_t         result;
	} pixel_run_t;

	logic clk;
	logic arst_n;

	cnv_pix_if  pix_ch ();
	cnv_feat_if feat_ch ();
	cnv_cfg_if  cfg_ch ();

	conv2d_valid_relu_bias dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.feat   (feat_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Directed table, run with the reset filter and bias and an image size of 5.
	// Three pixels of an image that is then abandoned carry the smallest value, the
	// lowest bit and the top bit alone. A start of image restarts the position, and a
	// whole 5x5 image of full-scale pixels follows. Its only window sums thirteen taps
	// of 1.0 times 255.996, far above the range, so the result clips at the top and
	// carries the end-of-image flag at output position (0, 0).
	pixel_run_t directed_runs [5] = '{
		'{16'h0000, 1'b1, 8'd1, 1'b0, '0},
		'{16'h0001, 1'b0, 8'd1, 1'b0, '0},
		'{16'h8000, 1'b0, 8'd1, 1'b0, '0},
		'{16'hFFFF, 1'b1, 8'd24, 1'b0, '0},
		'{16'hFFFF, 1'b0, 8'd1, 1'b1, '{16'hFFFF, 6'd0, 6'd0, 1'b1}}
	};

	// Predictor state: its own copy of the registers, the line stores, the window
	// and the raster position.
	logic [COEF_ROW_W-1:0] coef_rows [LANES];
	logic [BIAS_W-1:0]     bias_reg;
	logic [SIZE_W-1:0]     size_reg;
	logic [PIX_W-1:0]      line_mem [KSZ-1][LINE_CAP];
	logic [PIX_W-1:0]      window [KSZ][KSZ];
	int unsigned           col_pos;
	int unsigned           row_pos;

	// Results still owed by the block, oldest first.
	feature_t feature_q [$];

	bit          src_burst;
	bit          snk_burst;
	int unsigned hold_reqs;
	int unsigned n_beats;
	int unsigned ready_hold;
	int unsigned n_pixels;
	int unsigned n_checked;
	int unsigned n_writes;
	int unsigned n_settings;
	int unsigned n_fail;

	// Moves one pixel through the predictor and tells whether it completes a window.
	function automatic bit convolve_pixel(input logic [PIX_W-1:0] px, input logic sof,
		output feature_t res);
		int unsigned              n;
		int unsigned              r;
		int unsigned              c;
		logic [PIX_W-1:0]         column [KSZ];
		logic signed [COEF_W-1:0] tap;
		longint                   acc;
		longint                   val;
		bit                       hit;

		// Sizes outside the range are clamped to the window edge and to 64.
		n = size_reg;
		if (n < KSZ) n = KSZ;
		if (n > LINE_CAP) n = LINE_CAP;

		// A start of image restarts the raster. A position left outside a smaller
		// image wraps the column first and then the row.
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= n) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= n) row_pos = 0;
		r = row_pos;
		c = col_pos;

		// The column runs from the oldest line to the new pixel; every line store moves
		// up by one row in this column.
		for (int k = 0; k < KSZ - 1; k++) column[k] = line_mem[k][c];
		column[KSZ-1] = px;
		for (int k = 0; k < KSZ - 1; k++) line_mem[k][c] = column[k+1];
		for (int k = 0; k < KSZ; k++) begin
			for (int l = 0; l < KSZ - 1; l++) window[k][l] = window[k][l+1];
			window[k][KSZ-1] = column[k];
		end

		res = '0;
		hit = 1'b0;
		if (r >= KSZ - 1 && c >= KSZ - 1) begin
			acc = 0;
			for (int k = 0; k < KSZ; k++) begin
				for (int l = 0; l < KSZ; l++) begin
					tap = coef_rows[k][COEF_W*l +: COEF_W];
					acc += longint'(window[k][l]) * longint'(tap);
				end
			end
			// ReLU, then truncation toward zero, then the bias, then saturation.
			val = (acc > 0) ? (acc >>> 8) : 0;
			val += longint'($signed(bias_reg));
			if (val < 0) val = 0;
			if (val > 65535) val = 65535;
			res.value = val[PIX_W-1:0];
			res.row   = POS_W'(r - (KSZ - 1));
			res.col   = POS_W'(c - (KSZ - 1));
			res.eoi   = (r == n - 1) && (c == n - 1);
			hit = 1'b1;
		end

		// After the last pixel of the image the position wraps to the top left.
		col_pos = c + 1;
		if (col_pos >= n) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= n) row_pos = 0;
		end
		return hit;
	endfunction

	// Offers one pixel beat after a random gap, and once it is taken records the
	// result it is owed, either the pinned one from the table or the predicted one.
	// Entered and left at a falling edge, so valid stays high between beats without gaps.
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof, input bit pinned,
		input feature_t pinned_res);
		int       gap;
		feature_t res;
		bit       hit;

		gap = src_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid          <= 1'b1;
		pix_ch.pixel          <= px;
		pix_ch.start_of_image <= sof;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		hit = convolve_pixel(px, sof, res);
		if (pinned) feature_q = {feature_q, pinned_res};
		else if (hit) feature_q = {feature_q, res};
		n_pixels++;
		@(negedge clk);
	endtask

	// One register write beat. Valid is left high for a following write; the caller
	// lowers it once the batch is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_COEF_ROW_0, CFG_COEF_ROW_1, CFG_COEF_ROW_2, CFG_COEF_ROW_3,
			CFG_COEF_ROW_4: coef_rows[idx] = data[COEF_ROW_W-1:0];
			CFG_BIAS_VALUE: bias_reg = data[BIAS_W-1:0];
			CFG_IMAGE_SIZE: size_reg = data[SIZE_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	// Waits until every owed result has arrived, then lets the pipeline run dry, since
	// pixels that complete no window may still be inside it.
	task automatic wait_drained();
		while (feature_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes every register for one setting of the random part. Bits above a narrow
	// register are filled with noise, which the block must drop.
	task automatic program_setting(input int ph);
		logic [COEF_ROW_W-1:0] rows [LANES];
		logic [COEF_W-1:0]     lane;
		logic [BIAS_W-1:0]     bias;
		logic [SIZE_W-1:0]     size;
		logic [CFG_DATA_W-1:0] junk;

		for (int k = 0; k < LANES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				case (ph)
					PH_SAT_HIGH: lane = 12'h7FF;
					PH_NEG_LOW, PH_NEG_BIAS: lane = 12'h800;
					PH_ZERO: lane = '0;
					default: begin
						// Small positive taps keep some sums inside the range.
						if ($urandom_range(0, 2) == 0) lane = COEF_W'($urandom_range(0, 511));
						else lane = COEF_W'($urandom());
					end
				endcase
				rows[k][COEF_W*l +: COEF_W] = lane;
			end
			if (ph == PH_RESET_FILTER) rows[k] = (k % 2 == 0) ? COEF_RESET_EVEN : COEF_RESET_ODD;
		end

		case (ph)
			PH_SAT_HIGH, PH_NEG_BIAS: bias = 16'h7FFF;
			PH_NEG_LOW: bias = 16'h8000;
			PH_ZERO: bias = 16'hFFFF;
			PH_RESET_FILTER: bias = BIAS_RESET;
			default: begin
				if ($urandom_range(0, 1) == 0) bias = BIAS_W'($urandom_range(0, 2048) - 1024);
				else bias = BIAS_W'($urandom());
			end
		endcase

		case (ph)
			PH_SAT_HIGH, PH_NEG_BIAS: size = 7'd5;
			PH_NEG_LOW: size = 7'd6;
			PH_ZERO: size = 7'd0;
			PH_RESET_FILTER: size = 7'd4;
			PH_WIDE: size = 7'd127;
			PH_HOLD: size = 7'd65;
			PH_SHRINK: size = SIZE_W'($urandom_range(5, 7));
			default: begin
				if ($urandom_range(0, 7) == 0) size = SIZE_W'($urandom_range(10, 16));
				else size = SIZE_W'($urandom_range(5, 9));
			end
		endcase

		for (int k = 0; k < LANES; k++) write_reg(cfg_idx_t'(CFG_COEF_ROW_0 + k), rows[k]);
		junk = CFG_DATA_W'({$urandom(), $urandom()});
		if (ph > PH_SHRINK && $urandom_range(0, 3) == 0) write_reg(CFG_SPARE, junk);
		write_reg(CFG_BIAS_VALUE, {junk[CFG_DATA_W-1:BIAS_W], bias});
		write_reg(CFG_IMAGE_SIZE, {junk[CFG_DATA_W-1:SIZE_W], size});
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	// Output side, sampling. Every feature beat is held against the oldest owed
	// result, field by field, and counted so that the driving side draws its next stall.
	always @(posedge clk) begin : feature_check
		feature_t got;
		feature_t want;

		if (arst_n && feat_ch.valid && feat_ch.ready) begin
			got = '{feat_ch.feature_value, feat_ch.out_row, feat_ch.out_col,
				feat_ch.end_of_image};
			if (feature_q.size() == 0) begin
				$error("unexpected feature beat: value %0d row %0d col %0d end %0d",
					got.value, got.row, got.col, got.eoi);
				n_fail++;
			end else begin
				want = feature_q.pop_front();
				if (got.value !== want.value) begin
					$error("feature_value: expected %0d, got %0d", want.value, got.value);
					n_fail++;
				end
				if (got.row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, got.row);
					n_fail++;
				end
				if (got.col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, got.col);
					n_fail++;
				end
				if (got.eoi !== want.eoi) begin
					$error("end_of_image: expected %0d, got %0d", want.eoi, got.eoi);
					n_fail++;
				end
				n_checked++;
			end
			n_beats++;
		end
	end

	// Output side, driving. After each beat ready drops for a freshly drawn number of
	// cycles, or for a long stretch when asked, so that the pipeline fills and the
	// pixel input stalls.
	always @(negedge clk) begin : ready_drive
		int unsigned beats_seen;
		int unsigned holds_seen;

		if (beats_seen != n_beats) begin
			beats_seen = n_beats;
			ready_hold = snk_burst ? 0 : $urandom_range(0, 15);
		end
		if (holds_seen != hold_reqs) begin
			holds_seen = hold_reqs;
			ready_hold = HOLD_CYCLES;
		end
		if (!arst_n || ready_hold != 0) begin
			feat_ch.ready <= 1'b0;
			if (arst_n) ready_hold--;
		end else begin
			feat_ch.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int unsigned      beats;
		logic [PIX_W-1:0] px;
		logic             sof;
		bit               calm;

		arst_n                = 1'b0;
		pix_ch.valid          = 1'b0;
		pix_ch.pixel          = '0;
		pix_ch.start_of_image = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = CFG_COEF_ROW_0;
		cfg_ch.data           = '0;

		// The predictor starts from the reset state of the block.
		for (int k = 0; k < LANES; k++) coef_rows[k] = (k % 2 == 0) ? COEF_RESET_EVEN : COEF_RESET_ODD;
		bias_reg = BIAS_RESET;
		size_reg = SIZE_RESET;
		line_mem = '{default: '0};
		window   = '{default: '0};
		col_pos  = 0;
		row_pos  = 0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: only the image size moves away from its reset value.
		write_reg(CFG_IMAGE_SIZE, CFG_DATA_W'(5));
		cfg_ch.valid <= 1'b0;
		foreach (directed_runs[i]) begin
			for (int b = 0; b < directed_runs[i].beats; b++) begin
				send_pixel(directed_runs[i].pixel, directed_runs[i].sof && b == 0,
					directed_runs[i].pinned && b == directed_runs[i].beats - 1,
					directed_runs[i].result);
			end
		end
		pix_ch.valid <= 1'b0;

		// Random part: whole images in raster order with random pixels, mostly
		// flowing straight on from one image to the next, sometimes flagged, and now
		// and then broken off by a stray start of image. Registers change only once
		// the block has drained; the raster position carries over on purpose, so a
		// smaller size meets a position outside the image.
		for (int ph = 0; ph < N_SETTINGS; ph++) begin
			wait_drained();
			program_setting(ph);
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);
			calm      = (ph == PH_WIDE || ph == PH_HOLD);
			case (ph)
				PH_WIDE: beats = WIDE_BEATS;
				PH_HOLD: begin
					beats = HOLD_BEATS;
					hold_reqs++;
				end
				default: beats = $urandom_range(30, 60);
			endcase
			for (int b = 0; b < beats; b++) begin
				case ($urandom_range(0, 3))
					0: px = PIX_W'($urandom());
					1: px = ($urandom_range(0, 1) == 0) ? '0 : '1;
					default: px = PIX_W'($urandom_range(0, 1023));
				endcase
				// The widest image starts cleanly so that its fifth row is reached,
				// and the held-off setting goes on with it unbroken.
				sof = (ph == PH_WIDE && b == 0)
					|| (row_pos == 0 && col_pos == 0 && $urandom_range(0, 1) == 1)
					|| (!calm && $urandom_range(0, 59) == 0);
				send_pixel(px, sof, 1'b0, '0);
			end
			pix_ch.valid <= 1'b0;
		end
		wait_drained();

		$display("Sent %0d pixel beats under %0d register settings (%0d register writes),",
			n_pixels, n_settings + 1, n_writes);
		$display("and checked %0d feature beats, with %0d mismatches.", n_checked, n_fail);
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: many times the slowest correct run.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
